// ----- design/ctp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_pkg: shared constants and types for the complex to polar converter
// Widths, CORDIC arctangent table, rounding constants and pipeline flags.
// ----------------------------------------------------------------------------
package ctp_pkg;

   localparam int SAMPLE_WIDTH_DEF     = 16;
   localparam int ANGLE_ITERATIONS_DEF = 16;

   localparam int MAG_WIDTH   = 16;
   localparam int PHASE_WIDTH = 16;

   // CORDIC datapath: samples are scaled up to a common fixed point
   localparam int CORDIC_SCALE = 60;
   localparam int CORDIC_WIDTH = 62;

   // angle accumulator, Q2.30 radians with headroom
   localparam int ANGLE_WIDTH = 34;
   localparam int ANGLE_DROP  = 17;
   localparam int TAB_DEPTH   = 32;

   localparam logic [ANGLE_WIDTH-1:0] PI_Q30     = 34'd3373259426;
   localparam logic [ANGLE_WIDTH-1:0] ROUND_HALF = ANGLE_WIDTH'(1) << (ANGLE_DROP - 1);
   localparam logic [PHASE_WIDTH-1:0] PHASE_MAX  = 16'd25736;

   // atan(2^-i) * 2^30, truncated
   localparam logic [ANGLE_WIDTH-1:0] ATAN_TAB [TAB_DEPTH] = '{
      34'h03243F6A8, 34'h01DAC6705, 34'h00FADBAFC, 34'h007F56EA6,
      34'h003FEAB76, 34'h001FFD55B, 34'h000FFFAAA, 34'h0007FFF55,
      34'h0003FFFEA, 34'h0001FFFFD, 34'h0000FFFFF, 34'h00007FFFF,
      34'h00003FFFF, 34'h00001FFFF, 34'h00000FFFF, 34'h000007FFF,
      34'h000003FFF, 34'h000001FFF, 34'h000000FFF, 34'h0000007FF,
      34'h0000003FF, 34'h0000001FF, 34'h0000000FF, 34'h00000007F,
      34'h00000003F, 34'h00000001F, 34'h00000000F, 34'h000000008,
      34'h000000004, 34'h000000002, 34'h000000001, 34'h000000000
   };

   // special cases carried alongside a request
   typedef struct packed {
      logic zero;
      logic axis;
      logic neg;
   } flag_type;

endpackage
`default_nettype wire

// ----- design/ctp_sqrt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_sqrt_cell: one digit of the integer square root chain
// One root bit per active cell (trial subtract of root + 4^K), registered.
// ----------------------------------------------------------------------------
module ctp_sqrt_cell #(
   parameter int SW     = 32,
   parameter int K      = 0,
   parameter bit ACTIVE = 1'b1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [SW-1:0] rem_i,
   input  logic [SW-1:0] root_i,
   output logic [SW-1:0] rem_o,
   output logic [SW-1:0] root_o
);

   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] root_ff, root_in;

   generate
      if (ACTIVE) begin : g_digit
         localparam logic [SW-1:0] BIT = SW'(1) << (2 * K);
         logic [SW-1:0] trial;

         always_comb begin
            trial = root_i + BIT;
            if (rem_i >= trial) begin
               rem_in  = rem_i - trial;
               root_in = (root_i >> 1) + BIT;
            end else begin
               rem_in  = rem_i;
               root_in = root_i >> 1;
            end
         end
      end else begin : g_pass
         always_comb begin
            rem_in  = rem_i;
            root_in = root_i;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule
`default_nettype wire

// ----- design/ctp_cordic_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_cordic_cell: one vectoring micro-rotation of the CORDIC chain
// If ACTIVE, rotates toward x axis by atan(2^-ITER), accumulates the angle.
// ----------------------------------------------------------------------------
module ctp_cordic_cell #(
   parameter int ITER   = 0,
   parameter bit ACTIVE = 1'b1
) (
   input  logic                                        clock,
   input  logic                                        en,
   input  logic signed [ctp_pkg::CORDIC_WIDTH-1:0]     x_i,
   input  logic signed [ctp_pkg::CORDIC_WIDTH-1:0]     y_i,
   input  logic signed [ctp_pkg::ANGLE_WIDTH-1:0]      z_i,
   output logic signed [ctp_pkg::CORDIC_WIDTH-1:0]     x_o,
   output logic signed [ctp_pkg::CORDIC_WIDTH-1:0]     y_o,
   output logic signed [ctp_pkg::ANGLE_WIDTH-1:0]      z_o
);

   logic signed [ctp_pkg::CORDIC_WIDTH-1:0] x_ff, x_in;
   logic signed [ctp_pkg::CORDIC_WIDTH-1:0] y_ff, y_in;
   logic signed [ctp_pkg::ANGLE_WIDTH-1:0]  z_ff, z_in;

   generate
      if (ACTIVE) begin : g_rot
         localparam logic [4:0] TAB_IDX = 5'(ITER);
         localparam logic signed [ctp_pkg::ANGLE_WIDTH-1:0] ANG =
            ctp_pkg::ATAN_TAB[TAB_IDX];
         logic signed [ctp_pkg::CORDIC_WIDTH-1:0] xs;
         logic signed [ctp_pkg::CORDIC_WIDTH-1:0] ys;

         always_comb begin
            xs = x_i >>> ITER;
            ys = y_i >>> ITER;
            if (!y_i[ctp_pkg::CORDIC_WIDTH-1]) begin
               x_in = x_i + ys;
               y_in = y_i - xs;
               z_in = z_i + ANG;
            end else begin
               x_in = x_i - ys;
               y_in = y_i + xs;
               z_in = z_i - ANG;
            end
         end
      end else begin : g_pass
         always_comb begin
            x_in = x_i;
            y_in = y_i;
            z_in = z_i;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule
`default_nettype wire

// ----- design/complex_to_polar.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_to_polar: rectangular to polar conversion of complex samples
// Rounded magnitude via a digit-per-cell square root chain, and atan2 phase
// (signed Q3.13 radians) via a rotation-per-cell CORDIC chain.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_stall is low, and returns one
// result per request, in order. The pipeline is one stage for the squares,
// one for their sum and the CORDIC setup, one cell per root bit and per
// micro-rotation in two chains padded to equal length that move in step,
// and the output register where both results are rounded. A two-entry output
// stage absorbs a stall on the result side; req_stall rises only once its
// spare entry is occupied, and then the whole pipeline holds.
module complex_to_polar #(
   parameter int SAMPLE_WIDTH     = ctp_pkg::SAMPLE_WIDTH_DEF,
   parameter int ANGLE_ITERATIONS = ctp_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_real_part,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_imag_part,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ctp_pkg::MAG_WIDTH-1:0]        rsp_magnitude,
   output logic signed [ctp_pkg::PHASE_WIDTH-1:0] rsp_phase
);

   localparam int SW = 2 * SAMPLE_WIDTH;
   localparam int L  = (SAMPLE_WIDTH > ANGLE_ITERATIONS) ? SAMPLE_WIDTH : ANGLE_ITERATIONS;
   localparam int CW = ctp_pkg::CORDIC_WIDTH;
   localparam int AW = ctp_pkg::ANGLE_WIDTH;
   localparam int PW = ctp_pkg::PHASE_WIDTH;
   localparam int CSHIFT = ctp_pkg::CORDIC_SCALE - SAMPLE_WIDTH;

   logic en;
   logic accept;

   // control
   logic [L+1:0] valid_ff, valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         skid_valid_ff, skid_valid_in;

   // stage A: squares
   logic signed [SAMPLE_WIDTH-1:0] re_ff, im_ff;
   logic signed [SW-1:0]           re_ext, im_ext;
   logic [SW-1:0]                  sq_re_ff, sq_im_ff;

   // stage B: sum and CORDIC setup feed the chains
   logic [SW-1:0]          rem_chain  [L+1];
   logic [SW-1:0]          root_chain [L+1];
   logic signed [CW-1:0]   x_chain    [L+1];
   logic signed [CW-1:0]   y_chain    [L+1];
   logic signed [AW-1:0]   z_chain    [L+1];
   ctp_pkg::flag_type      flag_ff    [L+1];

   logic [SW-1:0]          rem0_ff;
   logic signed [CW-1:0]   x0_ff, y0_ff, x0_in, y0_in, re_sc, im_sc;
   logic signed [AW-1:0]   z0_ff, z0_in;
   ctp_pkg::flag_type      flag0_in;

   // result rounding
   logic [SW-1:0]          mag_full;
   logic signed [AW-1:0]   z_t;
   logic [AW-1:0]          z_abs, z_rnd;
   logic [PW-1:0]          ph_abs;
   logic signed [PW-1:0]   ph_new;
   logic [ctp_pkg::MAG_WIDTH-1:0] mag_new;
   logic                   out_take, tail_push;

   logic [ctp_pkg::MAG_WIDTH-1:0] rsp_mag_ff, skid_mag_ff;
   logic signed [PW-1:0]          rsp_ph_ff, skid_ph_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   // stage A
   assign re_ext = SW'(req_real_part);
   assign im_ext = SW'(req_imag_part);

   always_ff @(posedge clock) begin
      if (en) begin
         re_ff    <= req_real_part;
         im_ff    <= req_imag_part;
         sq_re_ff <= SW'(re_ext * re_ext);
         sq_im_ff <= SW'(im_ext * im_ext);
      end
   end

   // stage B
   always_comb begin
      re_sc = CW'(re_ff) <<< CSHIFT;
      im_sc = CW'(im_ff) <<< CSHIFT;
      flag0_in.zero = (re_ff == '0) && (im_ff == '0);
      flag0_in.axis = (im_ff == '0);
      flag0_in.neg  = re_ff[SAMPLE_WIDTH-1];
      if (flag0_in.neg) begin
         x0_in = -re_sc;
         y0_in = -im_sc;
         z0_in = im_ff[SAMPLE_WIDTH-1] ? -$signed(ctp_pkg::PI_Q30)
                                       : $signed(ctp_pkg::PI_Q30);
      end else begin
         x0_in = re_sc;
         y0_in = im_sc;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem0_ff    <= sq_re_ff + sq_im_ff;
         x0_ff      <= x0_in;
         y0_ff      <= y0_in;
         z0_ff      <= z0_in;
         flag_ff[0] <= flag0_in;
      end
   end

   assign rem_chain[0]  = rem0_ff;
   assign root_chain[0] = '0;
   assign x_chain[0]    = x0_ff;
   assign y_chain[0]    = y0_ff;
   assign z_chain[0]    = z0_ff;

   // the two chains
   generate
      for (genvar j = 0; j < L; j++) begin : g_cell
         ctp_sqrt_cell #(
            .SW     (SW),
            .K      (L - 1 - j),
            .ACTIVE ((L - 1 - j) < SAMPLE_WIDTH)
         ) u_sqrt (
            .clock  (clock),
            .en     (en),
            .rem_i  (rem_chain[j]),
            .root_i (root_chain[j]),
            .rem_o  (rem_chain[j+1]),
            .root_o (root_chain[j+1])
         );

         ctp_cordic_cell #(
            .ITER   (j),
            .ACTIVE (j < ANGLE_ITERATIONS)
         ) u_cordic (
            .clock (clock),
            .en    (en),
            .x_i   (x_chain[j]),
            .y_i   (y_chain[j]),
            .z_i   (z_chain[j]),
            .x_o   (x_chain[j+1]),
            .y_o   (y_chain[j+1]),
            .z_o   (z_chain[j+1])
         );

         always_ff @(posedge clock) begin
            if (en) begin
               flag_ff[j+1] <= flag_ff[j];
            end
         end
      end
   endgenerate

   // rounding of both results at the chain tail
   always_comb begin
      mag_full = (rem_chain[L] > root_chain[L]) ? root_chain[L] + SW'(1) : root_chain[L];
      mag_new  = mag_full[ctp_pkg::MAG_WIDTH-1:0];

      z_t   = z_chain[L];
      z_abs = z_t[AW-1] ? AW'(-z_t) : AW'(z_t);
      z_rnd = (z_abs + ctp_pkg::ROUND_HALF) >> ctp_pkg::ANGLE_DROP;
      if (z_rnd > AW'(ctp_pkg::PHASE_MAX)) begin
         ph_abs = ctp_pkg::PHASE_MAX;
      end else begin
         ph_abs = z_rnd[PW-1:0];
      end

      if (flag_ff[L].zero) begin
         ph_new = '0;
      end else if (flag_ff[L].axis) begin
         ph_new = flag_ff[L].neg ? $signed(ctp_pkg::PHASE_MAX) : '0;
      end else if (z_t[AW-1]) begin
         ph_new = -$signed(ph_abs);
      end else begin
         ph_new = $signed(ph_abs);
      end
   end

   // valid tracking and output stage
   assign out_take  = rsp_valid_ff && !rsp_stall;
   assign tail_push = en && valid_ff[L+1];

   always_comb begin
      valid_in      = en ? {valid_ff[L:0], accept} : valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_in = 1'b0;
         end
      end else if (tail_push) begin
         rsp_valid_in = 1'b1;
         if (rsp_valid_ff && !out_take) begin
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_mag_ff <= skid_mag_ff;
            rsp_ph_ff  <= skid_ph_ff;
         end
      end else if (tail_push) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_mag_ff <= mag_new;
            rsp_ph_ff  <= ph_new;
         end else begin
            skid_mag_ff <= mag_new;
            skid_ph_ff  <= ph_new;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_mag_ff;
   assign rsp_phase     = rsp_ph_ff;

endmodule
`default_nettype wire
